### design/qli_pkg.sv
// Shared constants, types and register indexes for the quantile block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package qli_pkg;

    localparam int ROW_MAX  = 256;
    localparam int CNT_W    = $clog2(ROW_MAX + 1);
    localparam int SAMPLE_W = 32;
    localparam int Q_W      = 17;
    localparam int LEN_W    = 9;
    localparam int CFG_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int P_W      = Q_W + CNT_W;
    localparam int PROD_W   = SAMPLE_W + Q_W + 1;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

    typedef enum logic {
        CFG_QUANTILE_Q = 1'b0,
        CFG_ROW_LENGTH = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                       insert;
        logic                       shift;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_ctl;

endpackage

### design/quantile_linear_interp.sv
// Top level of the streaming quantile block with linear interpolation.
// Depends on qli_pkg, qli_chain and qli_interp.
`timescale 1ns / 1ps

// Samples are taken one per cycle while a row fills; each is sorted into
// place in the cell chain in the cycle it is accepted. When the last sample
// of a row arrives the block stops taking samples and works through its
// steps in order: it forms the position, whose integer part lo is that of
// quantile_q * (n - 1) with quantile_q capped at one; it shifts the chain
// down until the two samples needed sit in its first two cells; it sees
// that the shift is done; it multiplies; and it adds. The result is held
// in an output register, so the next row may start filling while it waits
// to be taken; if the previous result is still waiting when a new one is
// ready, the block holds in its last step until the earlier result has
// been taken.
module quantile_linear_interp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [qli_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_result_valid,
    input  logic                                i_result_ready,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_quantile_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_SHIFT,
        S_MUL,
        S_SUM
    } t_state;

    t_state                              r_state;
    logic [qli_pkg::Q_W-1:0]             r_q;
    logic [qli_pkg::LEN_W-1:0]           r_row_len;
    logic [qli_pkg::CNT_W-1:0]           r_fill;
    logic [qli_pkg::CNT_W-1:0]           r_n;
    logic [qli_pkg::CNT_W-1:0]           r_lo;
    logic [qli_pkg::FRAC_W-1:0]          r_frac;
    logic signed [qli_pkg::SAMPLE_W-1:0] r_out;
    logic                                r_out_valid;

    logic                                w_accept;
    logic                                w_out_load;
    logic [qli_pkg::CNT_W-1:0]           w_len;
    logic [qli_pkg::CNT_W-1:0]           w_fill_inc;
    logic [qli_pkg::Q_W-1:0]             w_q_sat;
    logic [qli_pkg::P_W-1:0]             w_pos;
    qli_pkg::t_cell_ctl                  w_ctl;
    logic signed [qli_pkg::SAMPLE_W-1:0] w_head0;
    logic signed [qli_pkg::SAMPLE_W-1:0] w_head1;
    logic signed [qli_pkg::SAMPLE_W-1:0] w_interp;

    assign o_sample_ready   = (r_state == S_IDLE);
    assign o_result_valid   = r_out_valid;
    assign o_quantile_value = r_out;
    assign w_accept         = i_sample_valid && o_sample_ready;
    assign w_fill_inc       = r_fill + 1'b1;
    assign w_out_load       = (r_state == S_SUM) && (!r_out_valid || i_result_ready);

    always_comb begin
        if (r_row_len == '0) begin
            w_len = qli_pkg::CNT_W'(1);
        end else if (int'(r_row_len) > qli_pkg::ROW_MAX) begin
            w_len = qli_pkg::CNT_W'(qli_pkg::ROW_MAX);
        end else begin
            w_len = qli_pkg::CNT_W'(r_row_len);
        end
    end

    assign w_q_sat = (r_q > qli_pkg::Q_ONE) ? qli_pkg::Q_ONE : r_q;
    assign w_pos   = qli_pkg::P_W'(w_q_sat) * qli_pkg::P_W'(r_n - 1'b1);

    assign w_ctl.insert = w_accept;
    assign w_ctl.shift  = (r_state == S_SHIFT) && (r_lo != '0);
    assign w_ctl.sample = i_sample;

    qli_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_fill  (r_fill),
        .o_head0 (w_head0),
        .o_head1 (w_head1)
    );

    qli_interp u_interp (
        .i_clk   (i_clk),
        .i_en    (r_state == S_MUL),
        .i_s_lo  (w_head0),
        .i_s_hi  (w_head1),
        .i_frac  (r_frac),
        .o_value (w_interp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q       <= qli_pkg::Q_W'(32768);
            r_row_len <= qli_pkg::LEN_W'(256);
        end else if (i_cfg_we) begin
            unique case (qli_pkg::t_cfg_index'(i_cfg_index))
                qli_pkg::CFG_QUANTILE_Q: r_q       <= i_cfg_data;
                qli_pkg::CFG_ROW_LENGTH: r_row_len <= i_cfg_data[qli_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_fill_inc >= w_len) begin
                            r_n     <= w_fill_inc;
                            r_fill  <= '0;
                            r_state <= S_POS;
                        end else begin
                            r_fill <= w_fill_inc;
                        end
                    end
                end
                S_POS: begin
                    r_lo    <= qli_pkg::CNT_W'(w_pos >> qli_pkg::FRAC_W);
                    r_frac  <= w_pos[qli_pkg::FRAC_W-1:0];
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_lo == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_lo <= r_lo - 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // Wait here until the previous result has been taken.
                    if (w_out_load) begin
                        r_out   <= w_interp;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/qli_cell.sv
// One slot of the sorting chain: holds a single sample.
// Depends on qli_pkg for the control struct and the sample width.
`timescale 1ns / 1ps

module qli_cell (
    input  logic                               i_clk,
    input  qli_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_occupied,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic                               i_left_gt,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_right_val,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_val,
    output logic                               o_gt
);

    logic signed [qli_pkg::SAMPLE_W-1:0] r_val;
    logic signed [qli_pkg::SAMPLE_W-1:0] n_val;

    // An empty slot counts as larger than any sample.
    assign o_gt  = !i_occupied || (r_val > i_ctl.sample);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            // Slots above the insertion point move up by one; the first
            // larger slot takes the new sample.
            if (o_gt) begin
                n_val = i_left_gt ? i_left_val : i_ctl.sample;
            end
        end else if (i_ctl.shift) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### design/qli_chain.sv
// Row of sorting cells that keeps the current row in ascending order.
// Depends on qli_pkg and qli_cell.
`timescale 1ns / 1ps

module qli_chain (
    input  logic                                i_clk,
    input  qli_pkg::t_cell_ctl                  i_ctl,
    input  logic [qli_pkg::CNT_W-1:0]           i_fill,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_head0,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_head1
);

    logic signed [qli_pkg::SAMPLE_W-1:0] w_val [qli_pkg::ROW_MAX];
    logic                                w_gt  [qli_pkg::ROW_MAX];

    for (genvar g = 0; g < qli_pkg::ROW_MAX; g++) begin : g_cell
        logic                                w_occ;
        logic signed [qli_pkg::SAMPLE_W-1:0] w_left_val;
        logic                                w_left_gt;
        logic signed [qli_pkg::SAMPLE_W-1:0] w_right_val;

        assign w_occ = (qli_pkg::CNT_W'(g) < i_fill);

        if (g == 0) begin : g_first
            assign w_left_val = i_ctl.sample;
            assign w_left_gt  = 1'b0;
        end else begin : g_inner
            assign w_left_val = w_val[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == qli_pkg::ROW_MAX - 1) begin : g_last
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        qli_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_occupied  (w_occ),
            .i_left_val  (w_left_val),
            .i_left_gt   (w_left_gt),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    assign o_head0 = w_val[0];

    if (qli_pkg::ROW_MAX > 1) begin : g_head1
        assign o_head1 = w_val[1];
    end else begin : g_head1_single
        assign o_head1 = w_val[0];
    end

endmodule

### design/qli_interp.sv
// Linear interpolation between the two samples at the head of the chain.
// Depends on qli_pkg for widths.
`timescale 1ns / 1ps

module qli_interp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_s_lo,
    input  logic signed [qli_pkg::SAMPLE_W-1:0] i_s_hi,
    input  logic [qli_pkg::FRAC_W-1:0]          i_frac,
    output logic signed [qli_pkg::SAMPLE_W-1:0] o_value
);

    logic [qli_pkg::Q_W-1:0]              w_wt_lo;
    logic signed [qli_pkg::SAMPLE_W-1:0]  w_s_hi;
    logic signed [qli_pkg::PROD_W-1:0]    r_prod_lo;
    logic signed [qli_pkg::PROD_W-1:0]    r_prod_hi;
    logic signed [qli_pkg::SUM_W-1:0]     w_sum;

    assign w_wt_lo = qli_pkg::Q_ONE - qli_pkg::Q_W'(i_frac);
    // With no fractional part the upper sample plays no role and may lie
    // beyond the row, so it is forced to zero.
    assign w_s_hi  = (i_frac == '0) ? '0 : i_s_hi;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_lo <= i_s_lo * $signed({1'b0, w_wt_lo});
            r_prod_hi <= w_s_hi * $signed({2'b00, i_frac});
        end
    end

    assign w_sum   = qli_pkg::SUM_W'(r_prod_lo) + qli_pkg::SUM_W'(r_prod_hi);
    assign o_value = w_sum[qli_pkg::FRAC_W +: qli_pkg::SAMPLE_W];

endmodule
